// ----- sv/sdfe_pkg.sv -----
package sdfe_pkg;

    localparam int DIGITS_DEF     = 5;
    localparam int BRIGHT_MAX_DEF = 7;

    localparam logic [7:0] CTRL_ADDR    = 8'h18;
    localparam logic [3:0] CURRENT_FULL = 4'hE;
    localparam logic [7:0] MODE_8SEG    = 8'h00;
    localparam logic [7:0] BLANK        = 8'h00;
    localparam logic [7:0] CTRL_OFF     = 8'h00;
    localparam logic [7:0] DP_MASK      = 8'h80;
    localparam logic [7:0] SEG_MASK     = 8'h7F;

    typedef enum logic [2:0] {
        REQ_SET_BYTE  = 3'd0,
        REQ_SET_DIGIT = 3'd1,
        REQ_SET_BIT   = 3'd2,
        REQ_BRIGHT    = 3'd3,
        REQ_ON_OFF    = 3'd4,
        REQ_CLEAR     = 3'd5,
        REQ_INIT      = 3'd6
    } t_req_type;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] position;
        logic [7:0] segments;
        logic [2:0] bit_index;
        logic       on_flag;
        logic [7:0] level;
    } t_req;

    function automatic logic [7:0] grid_addr(input logic [2:0] idx);
        logic [7:0] a;
        unique case (idx)
            3'd0:    a = 8'h08;
            3'd1:    a = 8'h88;
            3'd2:    a = 8'h48;
            3'd3:    a = 8'hC8;
            3'd4:    a = 8'h28;
            default: a = 8'h00;
        endcase
        return a;
    endfunction

endpackage

// ----- sv/sdfe_if.sv -----
interface sdfe_req_if;
    logic                   valid;
    logic                   ready;
    logic [2:0]             req_type;
    logic [2:0]             position;
    logic [7:0]             segments;
    logic [2:0]             bit_index;
    logic                   on_flag;
    logic [7:0]             level;

    modport source (output valid, req_type, position, segments, bit_index, on_flag, level,
                    input ready);
    modport sink   (input valid, req_type, position, segments, bit_index, on_flag, level,
                    output ready);
endinterface

interface sdfe_frm_if;
    logic        valid;
    logic        ready;
    logic [7:0]  addr_byte;
    logic [7:0]  data_byte;
    logic [10:0] addr_line_word;
    logic [10:0] data_line_word;
    logic        last;

    modport source (output valid, addr_byte, data_byte, addr_line_word, data_line_word, last,
                    input ready);
    modport sink   (input valid, addr_byte, data_byte, addr_line_word, data_line_word, last,
                    output ready);
endinterface

// ----- sv/sdfe_line_enc.sv -----
module sdfe_line_enc (
    input  logic [7:0]  i_byte,
    output logic [10:0] o_word
);
    // start 0, data LSB first, odd parity, stop 1
    assign o_word = {1'b1, ~(^i_byte), i_byte, 1'b0};
endmodule

// ----- sv/segment_display_frame_encoder.sv -----
// Seven-segment display command encoder.
// i_req (sink): one display command per transfer (set byte, set digit, set bit,
//   brightness, on/off, clear, init). o_frm (source): one transfer per frame,
//   address and data bytes plus their 11-bit line words; last marks the final
//   frame of a command.
// A command is taken into an input register; a frame sequencer then emits one
//   frame per cycle into the output register while it can take a frame. The
//   first frame passes the input and then the output register. A command emits
//   one frame for single writes, DIGITS for clear and DIGITS+1 for init; bad
//   positions and unused codes emit no frame but still pass the sequencer.
// The next command is accepted in the cycle the current one emits its last frame,
//   so back-to-back single-frame commands run at one per cycle unless o_frm stalls.
// When o_frm.ready is low with a frame held, the output register keeps it and the
//   sequencer stops; i_req.ready is low while a command is held, unless it finishes.
// Reset clears all digit shadows, brightness and the on flag, and drops both
//   valid flags.
module segment_display_frame_encoder #(
    parameter int DIGITS     = sdfe_pkg::DIGITS_DEF,
    parameter int BRIGHT_MAX = sdfe_pkg::BRIGHT_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdfe_req_if.sink   i_req,
    sdfe_frm_if.source o_frm
);
    import sdfe_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W = $clog2(DIGITS + 1);

    logic             r_req_valid;
    t_req             r_req;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_shadow [DIGITS];
    logic [2:0]       r_bright;
    logic             r_enabled;

    logic             r_out_valid;
    logic [7:0]       r_addr;
    logic [7:0]       r_data;
    logic [10:0]      r_addr_word;
    logic [10:0]      r_data_word;
    logic             r_last;

    logic             adv;
    logic             done;
    logic             emit;
    logic [7:0]       n_addr;
    logic [7:0]       n_data;
    logic [10:0]      n_addr_word;
    logic [10:0]      n_data_word;
    logic             sh_we;
    logic [IDX_W-1:0] sh_idx;
    logic [7:0]       sh_wdata;
    logic             ctrl_we;
    logic             pos_ok;
    logic [IDX_W-1:0] pos_idx;
    logic [7:0]       sh_rd;
    logic [2:0]       new_bright;
    logic [2:0]       eff_bright;
    logic             eff_enabled;
    logic [7:0]       ctrl_byte;
    logic [7:0]       bit_mask;
    logic             clr_end;

    assign adv     = r_req_valid && (!r_out_valid || o_frm.ready);
    assign pos_ok  = r_req.position < 3'(DIGITS);
    assign pos_idx = r_req.position[IDX_W-1:0];
    assign sh_rd   = r_shadow[pos_idx];
    assign bit_mask = 8'(1) << r_req.bit_index;
    assign clr_end = r_cnt == CNT_W'(DIGITS - 1);

    assign new_bright = (r_req.level > 8'(BRIGHT_MAX)) ? 3'(BRIGHT_MAX) : r_req.level[2:0];

    always_comb begin
        eff_bright  = r_bright;
        eff_enabled = r_enabled;
        if (r_req.req_type == REQ_BRIGHT || r_req.req_type == REQ_INIT) begin
            eff_bright = new_bright;
        end
        if (r_req.req_type == REQ_ON_OFF || r_req.req_type == REQ_INIT) begin
            eff_enabled = r_req.on_flag;
        end
        ctrl_byte = eff_enabled ? ({{eff_bright, 1'b1}, CURRENT_FULL} | MODE_8SEG) : CTRL_OFF;
    end

    always_comb begin
        done     = 1'b1;
        emit     = 1'b0;
        n_addr   = CTRL_ADDR;
        n_data   = ctrl_byte;
        sh_we    = 1'b0;
        sh_idx   = pos_idx;
        sh_wdata = r_req.segments;
        ctrl_we  = 1'b0;
        unique case (t_req_type'(r_req.req_type))
            REQ_SET_BYTE: begin
                sh_we    = pos_ok;
                sh_wdata = r_req.segments;
            end
            REQ_SET_DIGIT: begin
                sh_we    = pos_ok;
                sh_wdata = (sh_rd & DP_MASK) | (r_req.segments & SEG_MASK);
            end
            REQ_SET_BIT: begin
                sh_we    = pos_ok;
                sh_wdata = r_req.on_flag ? (sh_rd | bit_mask) : (sh_rd & ~bit_mask);
            end
            REQ_BRIGHT, REQ_ON_OFF: begin
                emit    = 1'b1;
                ctrl_we = 1'b1;
            end
            REQ_CLEAR: begin
                done     = clr_end;
                sh_we    = 1'b1;
                sh_idx   = r_cnt[IDX_W-1:0];
                sh_wdata = BLANK;
            end
            REQ_INIT: begin
                done    = r_cnt == CNT_W'(DIGITS);
                ctrl_we = done;
                if (done) begin
                    emit = 1'b1;
                end else begin
                    sh_we    = 1'b1;
                    sh_idx   = r_cnt[IDX_W-1:0];
                    sh_wdata = BLANK;
                end
            end
            default: begin
            end
        endcase
        if (sh_we) begin
            emit   = 1'b1;
            n_addr = grid_addr(3'(sh_idx));
            n_data = sh_wdata;
        end
    end

    sdfe_line_enc u_addr_enc (
        .i_byte (n_addr),
        .o_word (n_addr_word)
    );

    sdfe_line_enc u_data_enc (
        .i_byte (n_data),
        .o_word (n_data_word)
    );

    assign i_req.ready = !r_req_valid || (adv && done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_bright    <= '0;
            r_enabled   <= 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                r_shadow[i] <= '0;
            end
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_req_valid     <= 1'b1;
                r_cnt           <= '0;
                r_req.req_type  <= i_req.req_type;
                r_req.position  <= i_req.position;
                r_req.segments  <= i_req.segments;
                r_req.bit_index <= i_req.bit_index;
                r_req.on_flag   <= i_req.on_flag;
                r_req.level     <= i_req.level;
            end else if (adv && done) begin
                r_req_valid <= 1'b0;
            end else if (adv) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (adv && emit) begin
                r_out_valid <= 1'b1;
                r_addr      <= n_addr;
                r_data      <= n_data;
                r_addr_word <= n_addr_word;
                r_data_word <= n_data_word;
                r_last      <= done;
            end else if (o_frm.ready) begin
                r_out_valid <= 1'b0;
            end

            if (adv && sh_we) begin
                r_shadow[sh_idx] <= sh_wdata;
            end
            if (adv && ctrl_we) begin
                r_bright  <= eff_bright;
                r_enabled <= eff_enabled;
            end
        end
    end

    assign o_frm.valid          = r_out_valid;
    assign o_frm.addr_byte      = r_addr;
    assign o_frm.data_byte      = r_data;
    assign o_frm.addr_line_word = r_addr_word;
    assign o_frm.data_line_word = r_data_word;
    assign o_frm.last           = r_last;

endmodule

// ----- sim/segment_display_frame_encoder_test.sv -----
module segment_display_frame_encoder_test;
    import sdfe_pkg::*;

    localparam int          DIGITS      = DIGITS_DEF;
    localparam int          BRIGHT_MAX  = BRIGHT_MAX_DEF;
    localparam logic [2:0]  REQ_UNUSED  = 3'd7;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          LONG_HOLD   = 300;
    localparam int          RANDOM_CMDS = 217;
    localparam int          TAIL_CYCLES = 20;

    typedef struct packed {
        logic [7:0]  addr_byte;
        logic [7:0]  data_byte;
        logic [10:0] addr_line_word;
        logic [10:0] data_line_word;
        logic        last;
    } t_frame;

    class display_frame_board;
        logic [7:0] shadow [DIGITS];
        logic [2:0] brightness;
        logic       enabled;
        t_frame     pending_frames [$];
        t_frame     cmd_frames [$];
        int         mismatches;

        function new();
            foreach (shadow[i]) shadow[i] = BLANK;
            brightness = '0;
            enabled    = 1'b0;
            mismatches = 0;
        endfunction

        function logic [7:0] digit_addr(int idx);
            logic [7:0] addr_tab [5];
            addr_tab = '{8'h08, 8'h88, 8'h48, 8'hC8, 8'h28};
            return addr_tab[idx];
        endfunction

        function logic [10:0] line_word(logic [7:0] b);
            return {1'b1, ~^b, b, 1'b0};
        endfunction

        function void add_frame(logic [7:0] addr, logic [7:0] data);
            t_frame f;
            f.addr_byte      = addr;
            f.data_byte      = data;
            f.addr_line_word = line_word(addr);
            f.data_line_word = line_word(data);
            f.last           = 1'b0;
            cmd_frames.push_back(f);
        endfunction

        function logic [7:0] ctrl_byte();
            logic [3:0] duty;
            if (!enabled)
                return CTRL_OFF;
            duty = {brightness, 1'b1};
            return {duty, CURRENT_FULL} | MODE_8SEG;
        endfunction

        function logic [2:0] clamp(logic [7:0] lv);
            return (lv > BRIGHT_MAX) ? 3'(BRIGHT_MAX) : lv[2:0];
        endfunction

        function void write_digit(int pos, logic [7:0] v);
            shadow[pos] = v;
            add_frame(digit_addr(pos), v);
        endfunction

        function void clear_digits();
            for (int i = 0; i < DIGITS; i++)
                write_digit(i, BLANK);
        endfunction

        function void add_command(t_req cmd);
            t_frame     f;
            logic [7:0] v;
            bit         pos_ok;
            pos_ok = cmd.position < DIGITS;
            cmd_frames.delete();
            case (cmd.req_type)
                REQ_SET_BYTE: begin
                    if (pos_ok)
                        write_digit(cmd.position, cmd.segments);
                end
                REQ_SET_DIGIT: begin
                    if (pos_ok)
                        write_digit(cmd.position, (shadow[cmd.position] & DP_MASK) |
                                                  (cmd.segments & SEG_MASK));
                end
                REQ_SET_BIT: begin
                    if (pos_ok) begin
                        v = shadow[cmd.position];
                        v[cmd.bit_index] = cmd.on_flag;
                        write_digit(cmd.position, v);
                    end
                end
                REQ_BRIGHT: begin
                    brightness = clamp(cmd.level);
                    add_frame(CTRL_ADDR, ctrl_byte());
                end
                REQ_ON_OFF: begin
                    enabled = cmd.on_flag;
                    add_frame(CTRL_ADDR, ctrl_byte());
                end
                REQ_CLEAR: begin
                    clear_digits();
                end
                REQ_INIT: begin
                    brightness = clamp(cmd.level);
                    enabled    = cmd.on_flag;
                    clear_digits();
                    add_frame(CTRL_ADDR, ctrl_byte());
                end
                default: ;
            endcase
            if (cmd_frames.size() > 0) begin
                f = cmd_frames.pop_back();
                f.last = 1'b1;
                cmd_frames.push_back(f);
            end
            foreach (cmd_frames[i]) pending_frames.push_back(cmd_frames[i]);
        endfunction

        function void check_frame(t_frame got);
            t_frame want;
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame: addr %h data %h aw %h dw %h last %b",
                             got.addr_byte, got.data_byte, got.addr_line_word,
                             got.data_line_word, got.last);
                return;
            end
            want = pending_frames.pop_front();
            if (got.addr_byte !== want.addr_byte || got.data_byte !== want.data_byte ||
                got.addr_line_word !== want.addr_line_word ||
                got.data_line_word !== want.data_line_word || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame mismatch: exp %h %h %h %h %b, got %h %h %h %h %b",
                             want.addr_byte, want.data_byte, want.addr_line_word,
                             want.data_line_word, want.last, got.addr_byte, got.data_byte,
                             got.addr_line_word, got.data_line_word, got.last);
            end
        endfunction

        function int frames_pending();
            return pending_frames.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    sdfe_req_if req_bus ();
    sdfe_frm_if frm_bus ();

    display_frame_board board;
    bit hold_req;
    bit burst_mode;
    int idle_cycles;

    segment_display_frame_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_frm   (frm_bus)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // accepted command transfers
    always @(posedge i_clk) begin
        t_req cmd;
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            cmd.req_type  = req_bus.req_type;
            cmd.position  = req_bus.position;
            cmd.segments  = req_bus.segments;
            cmd.bit_index = req_bus.bit_index;
            cmd.on_flag   = req_bus.on_flag;
            cmd.level     = req_bus.level;
            board.add_command(cmd);
        end
    end

    // accepted frame transfers
    always @(posedge i_clk) begin
        t_frame got;
        if (i_rst_n && frm_bus.valid && frm_bus.ready) begin
            got.addr_byte      = frm_bus.addr_byte;
            got.data_byte      = frm_bus.data_byte;
            got.addr_line_word = frm_bus.addr_line_word;
            got.data_line_word = frm_bus.data_line_word;
            got.last           = frm_bus.last;
            board.check_frame(got);
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (frm_bus.valid && frm_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // frame receiver
    initial begin
        int r;
        frm_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                frm_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                frm_bus.ready <= 1'b1;
                r = $urandom_range(0, 99);
                repeat ((r < 15) ? $urandom_range(20, 60) : $urandom_range(1, 6))
                    @(posedge i_clk);
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    frm_bus.ready <= 1'b0;
                    repeat ((r < 6) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                        @(posedge i_clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_req make_cmd(logic [2:0] kind, logic [2:0] pos, logic [7:0] seg,
                                      logic [2:0] bidx, logic onf, logic [7:0] lv);
        t_req cmd;
        cmd.req_type  = kind;
        cmd.position  = pos;
        cmd.segments  = seg;
        cmd.bit_index = bidx;
        cmd.on_flag   = onf;
        cmd.level     = lv;
        return cmd;
    endfunction

    function automatic t_req random_cmd();
        t_req cmd;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 25)      cmd.req_type = REQ_SET_BYTE;
        else if (r < 45) cmd.req_type = REQ_SET_DIGIT;
        else if (r < 70) cmd.req_type = REQ_SET_BIT;
        else if (r < 78) cmd.req_type = REQ_BRIGHT;
        else if (r < 85) cmd.req_type = REQ_ON_OFF;
        else if (r < 91) cmd.req_type = REQ_CLEAR;
        else if (r < 97) cmd.req_type = REQ_INIT;
        else             cmd.req_type = REQ_UNUSED;
        cmd.position  = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, DIGITS - 1))
                                                     : 3'($urandom_range(0, 7));
        cmd.segments  = 8'($urandom_range(0, 255));
        cmd.bit_index = 3'($urandom_range(0, 7));
        cmd.on_flag   = 1'($urandom_range(0, 1));
        cmd.level     = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 255));
        return cmd;
    endfunction

    task automatic send_cmd(input t_req cmd, input int gap);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= cmd.req_type;
        req_bus.position  <= cmd.position;
        req_bus.segments  <= cmd.segments;
        req_bus.bit_index <= cmd.bit_index;
        req_bus.on_flag   <= cmd.on_flag;
        req_bus.level     <= cmd.level;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic drain_frames();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.frames_pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_req directed [$];
        board      = new();
        hold_req   = 1'b0;
        burst_mode = 1'b0;
        idle_cycles = 0;
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= '0;
        req_bus.position  <= '0;
        req_bus.segments  <= '0;
        req_bus.bit_index <= '0;
        req_bus.on_flag   <= 1'b0;
        req_bus.level     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_cmd(REQ_INIT,      3'd0, 8'h00, 3'd0, 1'b1, 8'hFF));
        directed.push_back(make_cmd(REQ_SET_BYTE,  3'd0, 8'hFF, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_BYTE,  3'd4, 8'h00, 3'd7, 1'b1, 8'hFF));
        directed.push_back(make_cmd(REQ_SET_BYTE,  3'd5, 8'hAA, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_BYTE,  3'd7, 8'h55, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_DIGIT, 3'd0, 8'h00, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_DIGIT, 3'd4, 8'hFF, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_DIGIT, 3'd6, 8'hFF, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_BIT,   3'd1, 8'h00, 3'd7, 1'b1, 8'h00));
        directed.push_back(make_cmd(REQ_SET_BIT,   3'd1, 8'h00, 3'd0, 1'b1, 8'h00));
        directed.push_back(make_cmd(REQ_SET_BIT,   3'd1, 8'h00, 3'd7, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_SET_BIT,   3'd5, 8'h00, 3'd3, 1'b1, 8'h00));
        directed.push_back(make_cmd(REQ_SET_DIGIT, 3'd1, 8'h80, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_BRIGHT,    3'd0, 8'h00, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_BRIGHT,    3'd0, 8'h00, 3'd0, 1'b0, 8'h07));
        directed.push_back(make_cmd(REQ_BRIGHT,    3'd0, 8'h00, 3'd0, 1'b0, 8'h08));
        directed.push_back(make_cmd(REQ_BRIGHT,    3'd0, 8'h00, 3'd0, 1'b0, 8'hFF));
        directed.push_back(make_cmd(REQ_ON_OFF,    3'd0, 8'h00, 3'd0, 1'b0, 8'h00));
        directed.push_back(make_cmd(REQ_BRIGHT,    3'd0, 8'h00, 3'd0, 1'b0, 8'h03));
        directed.push_back(make_cmd(REQ_ON_OFF,    3'd0, 8'h00, 3'd0, 1'b1, 8'h00));
        directed.push_back(make_cmd(REQ_CLEAR,     3'd7, 8'hFF, 3'd7, 1'b1, 8'hFF));
        directed.push_back(make_cmd(REQ_UNUSED,    3'd0, 8'hFF, 3'd0, 1'b1, 8'hFF));
        directed.push_back(make_cmd(REQ_INIT,      3'd7, 8'hFF, 3'd7, 1'b0, 8'h00));
        foreach (directed[i]) send_cmd(directed[i], pick_gap());
        drain_frames();

        // long receiver hold-off while commands keep coming back to back
        hold_req   = 1'b1;
        wait (hold_req == 1'b0);
        burst_mode = 1'b1;
        repeat (20) send_cmd(random_cmd(), 0);
        burst_mode = 1'b0;
        drain_frames();

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 50 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            send_cmd(random_cmd(), pick_gap());
        end
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.frames_pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.frames_pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sdfe_pkg.sv
sv/sdfe_if.sv
sv/sdfe_line_enc.sv
sv/segment_display_frame_encoder.sv
sim/segment_display_frame_encoder_test.sv
